@@ hw/rtl/multicast_hash_mask_builder_top_defines.svh @@
// ---------------------------------------------------------------------------
// Multicast hash mask builder assertion macros
// Shared property templates for the checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef MULTICAST_HASH_MASK_BUILDER_TOP_DEFINES_SVH
`define MULTICAST_HASH_MASK_BUILDER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define MHMB_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("multicast hash mask builder check failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define MHMB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("multicast hash mask builder check failed");

`endif

@@ hw/rtl/mhmb_pkg.sv @@
// ---------------------------------------------------------------------------
// Multicast hash mask builder package
// Shared widths, register codes, queue entry types and CRC hash tables.
// ---------------------------------------------------------------------------
`default_nettype none

package mhmb_pkg;

	localparam int AddrWidth  = 48;
	localparam int MaskWidth  = 64;
	localparam int MaskIdxW   = $clog2(MaskWidth);
	localparam int CountWidth = 7;
	localparam int HashBits   = 6;
	localparam int CfgIdxW    = 2;
	localparam int CfgDataW   = 7;
	localparam int QDepth     = 2;
	localparam int QPtrW      = $clog2(QDepth);
	localparam int QCntW      = $clog2(QDepth + 1);

	localparam logic [31:0] CrcPoly   = 32'hEDB8_8320;
	localparam logic [31:0] CrcPreset = 32'hFFFF_FFFF;

	localparam logic [CountWidth-1:0] CountMax     = '1;
	localparam logic [CountWidth-1:0] MaxCountInit = 7'd64;

	typedef enum logic [CfgIdxW-1:0] {
		RegPromiscuous  = 2'd0,
		RegAllMulticast = 2'd1,
		RegMaxHashed    = 2'd2
	} cfg_reg_t;

	// One classified address as it travels from the front to the back.
	typedef struct packed {
		logic                hit;
		logic [MaskIdxW-1:0] idx;
		logic                last;
	} hash_entry_t;

	typedef struct packed {
		logic                  promiscuous;
		logic                  all_multicast;
		logic [CountWidth-1:0] max_count;
	} filter_cfg_t;

	// Runs the bit-serial reflected CRC over a whole address word.
	function automatic logic [31:0] crc_serial(logic [31:0] seed, logic [AddrWidth-1:0] data);
		logic [31:0] c;
		c = seed;
		for (int i = 0; i < AddrWidth; i++) begin
			if (c[0] ^ data[i]) begin
				c = (c >> 1) ^ CrcPoly;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	// The CRC is linear, so each address bit contributes a fixed column.
	function automatic logic [AddrWidth-1:0][31:0] crc_columns();
		logic [AddrWidth-1:0][31:0] cols;
		logic [AddrWidth-1:0]       unit;
		for (int k = 0; k < AddrWidth; k++) begin
			unit    = '0;
			unit[k] = 1'b1;
			cols[k] = crc_serial(32'd0, unit);
		end
		return cols;
	endfunction

	localparam logic [AddrWidth-1:0][31:0] CrcCols       = crc_columns();
	localparam logic [31:0]                CrcPresetTerm = crc_serial(CrcPreset, '0);

	// Bit-reverses the low HashBits of the CRC; bits beyond the mask width drop out.
	function automatic logic [MaskIdxW-1:0] hash_index(logic [31:0] crc);
		logic [MaskIdxW-1:0] idx;
		idx = '0;
		for (int i = 0; i < HashBits; i++) begin
			if (HashBits - 1 - i < MaskIdxW) begin
				idx[HashBits-1-i] = crc[i];
			end
		end
		return idx;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/mhmb_front.sv @@
// ---------------------------------------------------------------------------
// Multicast hash mask builder front end
// Accepts addresses, classifies multicast and computes the hash index.
// ---------------------------------------------------------------------------
`default_nettype none

module mhmb_front import mhmb_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [AddrWidth-1:0] mac_address,
	input  wire logic                 last_address,
	output logic                      push_valid,
	output hash_entry_t               push_data,
	input  wire logic                 queue_full
);

	logic        valid_s1;
	hash_entry_t entry_s1;
	hash_entry_t entry_next;
	logic [31:0] crc;
	logic        load;
	logic        push_accept;

	// The CRC is an XOR of one precomputed column per set address bit.
	always_comb begin
		crc = CrcPresetTerm;
		for (int k = 0; k < AddrWidth; k++) begin
			if (mac_address[k]) begin
				crc = crc ^ CrcCols[k];
			end
		end
		entry_next.hit  = mac_address[0];
		entry_next.idx  = hash_index(crc);
		entry_next.last = last_address;
	end

	assign push_accept = valid_s1 && !queue_full;
	assign in_stall    = valid_s1 && queue_full;
	assign load        = in_valid && !in_stall;
	assign push_valid  = valid_s1;
	assign push_data   = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (push_accept) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			entry_s1 <= entry_next;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/mhmb_queue.sv @@
// ---------------------------------------------------------------------------
// Multicast hash mask builder queue
// Short FIFO of classified entries between the front and the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module mhmb_queue import mhmb_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire hash_entry_t push_data,
	output logic       full,
	input  wire logic  pop,
	output hash_entry_t pop_data,
	output logic       empty
);

	hash_entry_t            entries_q [QDepth];
	logic [QPtrW-1:0]       wr_ptr_q;
	logic [QPtrW-1:0]       rd_ptr_q;
	logic [QCntW-1:0]       count_q;
	logic                   do_push;
	logic                   do_pop;

	assign full     = (count_q == QCntW'(QDepth));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/mhmb_back.sv @@
// ---------------------------------------------------------------------------
// Multicast hash mask builder back end
// Accumulates the mask and list length and issues the final result.
// ---------------------------------------------------------------------------
`default_nettype none

module mhmb_back import mhmb_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire filter_cfg_t          cfg,
	input  wire logic                 queue_empty,
	input  wire hash_entry_t          entry,
	output logic                      pop,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [MaskWidth-1:0]      hash_mask,
	output logic                      promiscuous,
	output logic                      mask_forced_full
);

	logic [MaskWidth-1:0]  acc_q;
	logic [CountWidth-1:0] count_q;
	logic [MaskWidth-1:0]  acc_next;
	logic [CountWidth-1:0] count_next;
	logic [MaskWidth-1:0]  bit_sel;
	logic                  out_valid_q;
	logic                  out_free;
	logic                  emit;
	logic                  force_full;

	assign out_free   = !out_valid_q || !out_stall;
	assign pop        = !queue_empty && (!entry.last || out_free);
	assign emit       = pop && entry.last;
	assign bit_sel    = entry.hit ? (MaskWidth'(1) << entry.idx) : '0;
	assign acc_next   = acc_q | bit_sel;
	assign count_next = (count_q == CountMax) ? count_q : count_q + 1'b1;
	assign force_full = cfg.all_multicast || (count_next > cfg.max_count);
	assign out_valid  = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				acc_q   <= entry.last ? '0 : acc_next;
				count_q <= entry.last ? '0 : count_next;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (cfg.promiscuous) begin
				hash_mask        <= '0;
				promiscuous      <= 1'b1;
				mask_forced_full <= 1'b0;
			end else if (force_full) begin
				hash_mask        <= '1;
				promiscuous      <= 1'b0;
				mask_forced_full <= 1'b1;
			end else begin
				hash_mask        <= acc_next;
				promiscuous      <= 1'b0;
				mask_forced_full <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/multicast_hash_mask_builder_top.sv @@
// The transaction that carries the last address of a list is registered in the front
// stage and passes through the queue, and then the output register takes the result;
// an output stall can hold it back. Throughput: one address transaction per cycle while the
// queue has room; the hash is a single XOR tree per address.
// Reset: arst_n clears the queue, the accumulated mask, the count and the output valid, and
// returns the registers to promiscuous off, all-multicast off and a threshold of 64.
// ---------------------------------------------------------------------------
// Multicast hash mask builder
// Builds a 64-bit Ethernet multicast hash filter mask from a list of MAC
// addresses using the low bits of a reflected CRC-32 of each address.
// ---------------------------------------------------------------------------
`default_nettype none

`include "multicast_hash_mask_builder_top_defines.svh"

module multicast_hash_mask_builder_top import mhmb_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// Configuration write port.
	input  wire logic                 wr_en,
	input  wire logic [CfgIdxW-1:0]   wr_index,
	input  wire logic [CfgDataW-1:0]  wr_data,
	// Address input channel.
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [AddrWidth-1:0] mac_address,
	input  wire logic                 last_address,
	// Result output channel.
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [MaskWidth-1:0]      hash_mask,
	output logic                      promiscuous,
	output logic                      mask_forced_full
);

	// Filter registers. The user must see that they are only written while no list is in flight; the
	// block does not enforce this, so the back end may read them directly when it closes a list.
	filter_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.promiscuous   <= 1'b0;
			cfg_q.all_multicast <= 1'b0;
			cfg_q.max_count     <= MaxCountInit;
		end else if (wr_en) begin
			unique case (cfg_reg_t'(wr_index))
				RegPromiscuous:  cfg_q.promiscuous   <= wr_data[0];
				RegAllMulticast: cfg_q.all_multicast <= wr_data[0];
				RegMaxHashed:    cfg_q.max_count     <= wr_data[CountWidth-1:0];
				default: begin
					// Writes to an unused index are dropped.
				end
			endcase
		end
	end

	// The front end registers each address together with its multicast flag and
	// hash index, and hands it to the queue. It stalls the input only while its
	// stage is occupied and the queue cannot take the entry.
	logic        push_valid;
	hash_entry_t push_data;
	logic        queue_full;
	logic        queue_empty;
	logic        pop;
	hash_entry_t pop_data;

	mhmb_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mac_address  (mac_address),
		.last_address (last_address),
		.push_valid   (push_valid),
		.push_data    (push_data),
		.queue_full   (queue_full)
	);

	// The queue lets the front keep accepting while the back end waits for the
	// output register to drain at the end of a list.
	mhmb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push_valid),
		.push_data (push_data),
		.full      (queue_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (queue_empty)
	);

	// The back end ORs each hashed bit into the mask and counts addresses. A
	// non-final entry is always consumed; a final entry waits until the output
	// register is free or is being emptied in the same cycle.
	mhmb_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.queue_empty      (queue_empty),
		.entry            (pop_data),
		.pop              (pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.hash_mask        (hash_mask),
		.promiscuous      (promiscuous),
		.mask_forced_full (mask_forced_full)
	);

	// Promiscuous mode wins over forcing, and then the mask is empty.
	`MHMB_ASSERT_NOW(a_promisc_clear, out_valid && promiscuous, (hash_mask == '0) && !mask_forced_full)
	// A forced result is a full mask.
	`MHMB_ASSERT_NOW(a_forced_full, out_valid && mask_forced_full, (&hash_mask) && !promiscuous)
	// The back end never takes an entry from an empty queue.
	`MHMB_ASSERT_NOW(a_pop_nonempty, pop, !queue_empty)
	// The front stalls only while its stage is busy and the queue is full.
	`MHMB_ASSERT_NOW(a_stall_full, in_stall, queue_full && push_valid)

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Multicast hash mask builder testbench
// Streams lists of MAC addresses into the block under randomly stalled
// handshakes, predicts each list's filter mask with a bit-serial CRC-32
// hash and compares every result transaction with that prediction. The
// run moves through several register settings, written while the block
// is idle, including promiscuous precedence, threshold overflow and count
// saturation.
// ---------------------------------------------------------------------------

module testbench;
	import mhmb_pkg::*;

	localparam int                   QuietLimit = 2000;
	localparam int                   SettleCycles = 8;
	localparam logic [CfgIdxW-1:0]   RegSpare = 2'd3;

	typedef struct packed {
		logic [AddrWidth-1:0] addr;
		logic                 is_last;
	} addr_txn_t;

	typedef struct packed {
		logic [MaskWidth-1:0] mask;
		logic                 promisc_flag;
		logic                 forced_full;
	} mask_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 wr_en = 1'b0;
	logic [CfgIdxW-1:0]   wr_index = '0;
	logic [CfgDataW-1:0]  wr_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [AddrWidth-1:0] mac_address = '0;
	logic                 last_address = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [MaskWidth-1:0] hash_mask;
	logic                 promiscuous;
	logic                 mask_forced_full;

	// Stimulus waiting to be presented and masks waiting to come out.
	addr_txn_t    pending_addrs[$];
	mask_result_t expected_masks[$];

	// Predicted register and list state.
	logic                  cfg_promisc = 1'b0;
	logic                  cfg_allmc = 1'b0;
	logic [CountWidth-1:0] cfg_max_len = MaxCountInit;
	logic [MaskWidth-1:0]  acc_mask = '0;
	logic [CountWidth-1:0] list_len = '0;

	int mismatch_count = 0;
	int quiet_cycles = 0;
	int send_gap_left = 0;
	int stall_left = 0;
	int in_idle_pct = 0;
	int out_idle_pct = 0;

	multicast_hash_mask_builder_top u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.wr_en            (wr_en),
		.wr_index         (wr_index),
		.wr_data          (wr_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.mac_address      (mac_address),
		.last_address     (last_address),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.hash_mask        (hash_mask),
		.promiscuous      (promiscuous),
		.mask_forced_full (mask_forced_full)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Reflected CRC-32 over the 48 address bits, first byte LSB first, then
	// the low hash bits reversed; anything above the mask width drops out.
	function automatic logic [MaskIdxW-1:0] crc_bucket(logic [AddrWidth-1:0] addr);
		logic [31:0] crc;
		logic [15:0] bucket;
		crc = CrcPreset;
		for (int i = 0; i < AddrWidth; i++) begin
			if (crc[0] ^ addr[i]) begin
				crc = (crc >> 1) ^ CrcPoly;
			end else begin
				crc = crc >> 1;
			end
		end
		bucket = '0;
		for (int i = 0; i < HashBits; i++) begin
			bucket = {bucket[14:0], crc[i]};
		end
		return bucket[MaskIdxW-1:0];
	endfunction

	// Updates the list state for one accepted address and, on the last one,
	// queues the mask that the list must produce.
	task automatic predict_address(logic [AddrWidth-1:0] addr, logic is_last);
		mask_result_t res;
		if (list_len != CountMax) begin
			list_len = list_len + 1'b1;
		end
		if (addr[0]) begin
			acc_mask[crc_bucket(addr)] = 1'b1;
		end
		if (is_last) begin
			res.mask         = acc_mask;
			res.promisc_flag = 1'b0;
			res.forced_full  = 1'b0;
			if (cfg_promisc) begin
				res.mask         = '0;
				res.promisc_flag = 1'b1;
			end else if (cfg_allmc || list_len > cfg_max_len) begin
				res.mask        = '1;
				res.forced_full = 1'b1;
			end
			expected_masks.push_back(res);
			acc_mask = '0;
			list_len = '0;
		end
	endtask

	task automatic report_mismatch(string what, mask_result_t want);
		if (mismatch_count < 10) begin
			$display("[%0t] %s: expected mask %h promisc %b full %b, got mask %h promisc %b full %b",
				$realtime, what, want.mask, want.promisc_flag, want.forced_full,
				hash_mask, promiscuous, mask_forced_full);
		end
		mismatch_count++;
	endtask

	// Address driver: presents pending transactions, holds a stalled one and
	// inserts random gaps.
	always @(posedge clk) begin
		addr_txn_t nxt;
		if (in_valid && !in_stall) begin
			predict_address(mac_address, last_address);
		end
		if (in_valid && in_stall) begin
			// Stalled transaction stays on the port unchanged.
		end else if (send_gap_left > 0) begin
			send_gap_left--;
			in_valid <= 1'b0;
		end else if (pending_addrs.size() != 0 && $urandom_range(0, 99) < in_idle_pct) begin
			send_gap_left = $urandom_range(1, 19) - 1;
			in_valid <= 1'b0;
		end else if (pending_addrs.size() != 0) begin
			nxt = pending_addrs.pop_front();
			in_valid     <= 1'b1;
			mac_address  <= nxt.addr;
			last_address <= nxt.is_last;
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Result monitor: checks each accepted mask against the oldest prediction
	// and applies random stall bursts.
	always @(posedge clk) begin
		mask_result_t want;
		if (out_valid && !out_stall) begin
			if (expected_masks.size() == 0) begin
				want = '0;
				report_mismatch("result with nothing expected", want);
			end else begin
				want = expected_masks.pop_front();
				if (hash_mask !== want.mask || promiscuous !== want.promisc_flag ||
						mask_forced_full !== want.forced_full) begin
					report_mismatch("result mismatch", want);
				end
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 99) < out_idle_pct) begin
			stall_left = $urandom_range(1, 19) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Watchdog: a long run of cycles with no transaction on either side
	// means the block has hung or a result has gone missing.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QuietLimit) begin
				$display("end of test: mismatches");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	function automatic logic [AddrWidth-1:0] random_mac(int mc_pct);
		logic [63:0] raw;
		raw    = {$urandom, $urandom};
		raw[0] = ($urandom_range(0, 99) < mc_pct);
		return raw[AddrWidth-1:0];
	endfunction

	task automatic queue_addr(logic [AddrWidth-1:0] addr, logic is_last);
		addr_txn_t t;
		t.addr    = addr;
		t.is_last = is_last;
		pending_addrs.push_back(t);
	endtask

	// Queues whole lists of random length until at least total addresses are
	// waiting; now and then an address repeats to hit the same bucket twice.
	task automatic queue_lists(int total, int min_len, int max_len, int mc_pct);
		int queued;
		int len;
		logic [AddrWidth-1:0] addr;
		logic [AddrWidth-1:0] prev;
		queued = 0;
		prev   = random_mac(mc_pct);
		while (queued < total) begin
			len = $urandom_range(min_len, max_len);
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(0, 9) == 0) begin
					addr = prev;
				end else begin
					addr = random_mac(mc_pct);
				end
				queue_addr(addr, k == len - 1);
				prev = addr;
			end
			queued += len;
		end
	endtask

	// Registers are only written once the block has gone quiet; the predicted
	// copy changes at the edge that takes the write.
	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			RegPromiscuous:  cfg_promisc = data[0];
			RegAllMulticast: cfg_allmc = data[0];
			RegMaxHashed:    cfg_max_len = data;
			default: ;
		endcase
	endtask

	// Waits until every address has gone in and every mask has come out, then
	// lets the pipeline settle.
	task automatic drain_and_settle();
		do @(negedge clk);
		while (pending_addrs.size() != 0 || in_valid || expected_masks.size() != 0);
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic pick_idling();
		in_idle_pct  = $urandom_range(0, 3) * 5;
		out_idle_pct = $urandom_range(0, 3) * 5;
	endtask

	initial begin
		logic [CfgDataW-1:0] noise;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed lists under the reset settings: the address extremes,
		// unicast-only lists, a repeated group address and a spread of buckets.
		in_idle_pct  = 10;
		out_idle_pct = 10;
		queue_addr(48'h0000_0000_0000, 1'b1);
		queue_addr(48'hFFFF_FFFF_FFFF, 1'b1);
		queue_addr(48'h0000_0000_0001, 1'b1);
		queue_addr(48'hFFFF_FFFF_FFFE, 1'b1);
		queue_addr(48'h0100_005E_0001, 1'b0);
		queue_addr(48'h0100_005E_0001, 1'b0);
		queue_addr(48'h0000_0000_0002, 1'b0);
		queue_addr(48'h3300_0033_3333, 1'b1);
		for (int k = 0; k < 16; k++) begin
			queue_addr(48'h1 | (48'h1 << (3 * k + 1)), k == 15);
		end
		drain_and_settle();

		// A low threshold: lists of up to three addresses hash, longer ones
		// force the mask full.
		write_reg(RegMaxHashed, 7'd3);
		pick_idling();
		queue_lists(100, 1, 6, 75);
		drain_and_settle();

		// Promiscuous mode wins over list overflow.
		noise = CfgDataW'($urandom);
		write_reg(RegPromiscuous, {noise[CfgDataW-1:1], 1'b1});
		pick_idling();
		queue_lists(50, 1, 6, 75);
		drain_and_settle();

		// ...and over all-multicast.
		noise = CfgDataW'($urandom);
		write_reg(RegAllMulticast, {noise[CfgDataW-1:1], 1'b1});
		pick_idling();
		queue_lists(40, 1, 6, 75);
		drain_and_settle();

		// All-multicast on its own forces every mask full.
		noise = CfgDataW'($urandom);
		write_reg(RegPromiscuous, {noise[CfgDataW-1:1], 1'b0});
		pick_idling();
		queue_lists(40, 1, 6, 75);
		drain_and_settle();

		// A threshold of zero: even a single address overflows.
		noise = CfgDataW'($urandom);
		write_reg(RegAllMulticast, {noise[CfgDataW-1:1], 1'b0});
		write_reg(RegMaxHashed, 7'd0);
		pick_idling();
		queue_lists(40, 1, 4, 75);
		drain_and_settle();

		// Top of the threshold range: 126 addresses still hash, 127 overflow.
		// A write to the spare index must leave every register alone.
		noise = CfgDataW'($urandom);
		write_reg(RegSpare, noise);
		write_reg(RegMaxHashed, 7'd126);
		pick_idling();
		queue_lists(126, 126, 126, 50);
		queue_lists(127, 127, 127, 50);
		drain_and_settle();

		// With a threshold of 127 the saturated count never overflows.
		write_reg(RegMaxHashed, 7'd127);
		pick_idling();
		queue_lists(130, 130, 130, 60);
		queue_lists(1, 1, 1, 100);
		drain_and_settle();

		// Back to the reset threshold, and full rate on both sides to finish.
		write_reg(RegMaxHashed, MaxCountInit);
		in_idle_pct  = 0;
		out_idle_pct = 0;
		queue_lists(100, 1, 20, 75);
		drain_and_settle();

		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
